### rtl/core/mcmp_pkg.sv
// Shared types and constants of the MIDI channel message parser.
package mcmp_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
  localparam logic [3:0] CMD_PROGRAM  = 4'd12;

  localparam logic [7:0] RT_CLOCK = 8'hF8;
  localparam logic [7:0] RT_SENSE = 8'hFE;

  localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
  localparam logic [2:0] KIND_POLY_PRESS = 3'd2;
  localparam logic [2:0] KIND_CTRL_CHG   = 3'd3;
  localparam logic [2:0] KIND_PROGRAM    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN    = 3'd5;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_STATUS,
    CLS_REALTIME
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

endpackage

### rtl/core/mcmp_front.sv
// Front end: accepts received words, classifies them and drops ignored real-time words.
module mcmp_front import mcmp_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output push_t      push_o
);

  logic is_rt;
  logic drop;

  always_comb begin
    is_rt = (in_rx_byte[7:3] == 5'b11111);
    drop  = (in_rx_byte == RT_CLOCK) || (in_rx_byte == RT_SENSE);
    push_o.item.rx_byte = in_rx_byte;
    priority if (!in_rx_byte[7]) begin
      push_o.item.cls = CLS_DATA;
    end else if (is_rt) begin
      push_o.item.cls = CLS_REALTIME;
    end else begin
      push_o.item.cls = CLS_STATUS;
    end
    push_o.push = in_valid && !q_full && !drop;
    in_stall    = q_full;
  end

endmodule

### rtl/core/mcmp_queue.sv
// Short queue of classified words between the front end and the back end.
module mcmp_queue import mcmp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push_i,
  output logic  full,
  input  logic  pop_ready,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full      = (cnt_r == CW'(DEPTH));
    pop_valid = (cnt_r != '0);
    pop_item  = mem_r[rd_ptr_r];
    do_push   = push_i.push && !full;
    do_pop    = pop_ready && pop_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.item;
    end
  end

endmodule

### rtl/core/mcmp_back.sv
// Back end: running-status state, message assembly and the output register.
module mcmp_back import mcmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  item_t      pop_item,
  output logic       pop_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_msg_kind,
  output logic [4:0] out_chan_num,
  output logic [7:0] out_first_value,
  output logic [6:0] out_second_value,
  output logic [7:0] out_raw_status
);

  logic [3:0] cmd_r, cmd_nxt;
  logic [3:0] chan_r, chan_nxt;
  logic [6:0] held_r, held_nxt;
  logic [1:0] count_r, count_nxt;
  logic       valid_r, valid_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [4:0] chnum_r, chnum_nxt;
  logic [7:0] first_r, first_nxt;
  logic [6:0] second_r, second_nxt;
  logic [7:0] raw_r, raw_nxt;
  logic       take;
  logic       emit;
  logic [7:0] b;

  always_comb begin
    b         = pop_item.rx_byte;
    pop_ready = !valid_r || !out_stall;
    take      = pop_valid && pop_ready;
    cmd_nxt   = cmd_r;
    chan_nxt  = chan_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    emit       = 1'b0;
    kind_nxt   = KIND_UNKNOWN;
    chnum_nxt  = {1'b0, b[3:0]} + 5'd1;
    first_nxt  = '0;
    second_nxt = '0;
    raw_nxt    = '0;
    if (take) begin
      unique case (pop_item.cls)
        CLS_REALTIME: begin
          emit    = 1'b1;
          raw_nxt = b;
        end
        CLS_STATUS: begin
          cmd_nxt   = b[7:4];
          chan_nxt  = b[3:0];
          count_nxt = '0;
          if (b[7:4] > CMD_PROGRAM) begin
            emit    = 1'b1;
            raw_nxt = b;
          end
        end
        CLS_DATA: begin
          chnum_nxt = {1'b0, chan_r} + 5'd1;
          priority if (cmd_r == CMD_PROGRAM) begin
            count_nxt = '0;
            emit      = 1'b1;
            kind_nxt  = KIND_PROGRAM;
            first_nxt = {1'b0, b[6:0]} + 8'd1;
          end else if (cmd_r[3:2] == CMD_NOTE_OFF[3:2]) begin
            if (count_r == 2'd0) begin
              held_nxt  = b[6:0];
              count_nxt = 2'd1;
            end else begin
              count_nxt  = '0;
              emit       = 1'b1;
              kind_nxt   = {1'b0, cmd_r[1:0]};
              first_nxt  = {1'b0, held_r};
              second_nxt = b[6:0];
            end
          end else begin
            if (count_r == 2'd0) begin
              held_nxt = b[6:0];
            end
            if (count_r < 2'd2) begin
              count_nxt = count_r + 2'd1;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    priority if (emit) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= '0;
      chan_r  <= '0;
      held_r  <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      cmd_r   <= cmd_nxt;
      chan_r  <= chan_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= kind_nxt;
      chnum_r  <= chnum_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      raw_r    <= raw_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_msg_kind     = kind_r;
  assign out_chan_num     = chnum_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_raw_status   = raw_r;

endmodule

### rtl/core/midi_channel_message_parser_top.sv
// Top level of the MIDI channel message parser with running status.
//
// Received MIDI words enter on the in_ channel (in_valid, in_stall, in_rx_byte),
// one word per cycle at most. Decoded channel messages leave on the out_ channel
// as kind, channel number, first and second value and, for unknown status, the
// raw status word. Running status is kept across messages.
// A front end classifies each word and discards timing clock and active sensing;
// a short queue feeds the back end, which holds the running state and a single
// output register. A result is offered once its last word is accepted and has
// passed the queue and the back end; the block sustains one word per cycle while
// the receiver takes results, a rate set by the back-end update and output register.
// When the receiver stalls, the output register holds its word, the back end waits
// and the queue fills; in_stall rises once the queue is full.
// Synchronous reset clears the queue, the output valid and the running state
// (no command, channel zero, no data held).
module midi_channel_message_parser_top import mcmp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_msg_kind,
  output logic [4:0] out_chan_num,
  output logic [7:0] out_first_value,
  output logic [6:0] out_second_value,
  output logic [7:0] out_raw_status
);

  push_t push;
  logic  q_full;
  logic  pop_ready;
  logic  pop_valid;
  item_t pop_item;

  mcmp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push_o     (push)
  );

  mcmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .full      (q_full),
    .pop_ready (pop_ready),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  mcmp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_msg_kind     (out_msg_kind),
    .out_chan_num     (out_chan_num),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_raw_status   (out_raw_status)
  );

  a_raw_only_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind != KIND_UNKNOWN) |-> out_raw_status == 8'd0)
    else $error("raw status set on a channel message");

  a_chan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chan_num != 5'd0 && out_chan_num <= 5'd16)
    else $error("channel number out of range");

  a_program_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind == KIND_PROGRAM) |->
      out_second_value == 7'd0 && out_first_value != 8'd0)
    else $error("malformed program change");

  a_unknown_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind == KIND_UNKNOWN) |->
      out_raw_status[7] && out_first_value == 8'd0 && out_second_value == 7'd0)
    else $error("malformed unknown-status message");

endmodule

### bench/midi_channel_message_parser_top_tb.sv
// Self-checking testbench for the MIDI channel message parser with running status.
`timescale 1ns / 1ps

module midi_channel_message_parser_top_tb;
  import mcmp_pkg::*;

  localparam logic [3:0] CMD_NOTE_ON    = 4'd9;
  localparam logic [3:0] CMD_POLY_PRESS = 4'd10;
  localparam logic [3:0] CMD_CTRL_CHG   = 4'd11;
  localparam logic [3:0] CMD_CHAN_PRESS = 4'd13;
  localparam logic [3:0] CMD_PITCH_BEND = 4'd14;
  localparam logic [3:0] CMD_SYSTEM     = 4'd15;
  localparam logic [7:0] RT_RESET       = 8'hFF;
  localparam logic [7:0] FIRST_UNKNOWN  = {CMD_CHAN_PRESS, 4'h0};
  localparam int CYCLE_LIMIT = 100000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] chan;
    logic [7:0] first;
    logic [6:0] second;
    logic [7:0] raw;
  } midi_msg_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_msg_kind;
  logic [4:0] out_chan_num;
  logic [7:0] out_first_value;
  logic [6:0] out_second_value;
  logic [7:0] out_raw_status;

  logic [7:0] word_q[$];
  midi_msg_t  pending_msgs[$];
  midi_msg_t  want;

  logic [3:0] run_cmd = 4'd0;
  logic [3:0] run_chan = 4'd0;
  logic [6:0] run_first = 7'd0;
  logic [1:0] run_count = 2'd0;

  logic in_took = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_wanted = 0;
  int   hold_count = 0;
  int   words_queued = 0;
  int   words_taken = 0;
  int   msgs_seen = 0;
  int   in_stall_cycles = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   kinds_seen[8];

  midi_channel_message_parser_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_msg_kind     (out_msg_kind),
    .out_chan_num     (out_chan_num),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_raw_status   (out_raw_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic decode_word(input logic [7:0] w);
    midi_msg_t m;
    m = '0;
    if (w[7]) begin
      if (w >= RT_CLOCK) begin
        if (w != RT_CLOCK && w != RT_SENSE) begin
          m.kind = KIND_UNKNOWN;
          m.chan = {1'b0, w[3:0]} + 5'd1;
          m.raw  = w;
          pending_msgs.push_back(m);
        end
      end else begin
        run_cmd   = w[7:4];
        run_chan  = w[3:0];
        run_count = 2'd0;
        if (run_cmd > CMD_PROGRAM) begin
          m.kind = KIND_UNKNOWN;
          m.chan = {1'b0, run_chan} + 5'd1;
          m.raw  = w;
          pending_msgs.push_back(m);
        end
      end
    end else if (run_cmd == CMD_PROGRAM) begin
      run_count = 2'd0;
      m.kind  = KIND_PROGRAM;
      m.chan  = {1'b0, run_chan} + 5'd1;
      m.first = {1'b0, w[6:0]} + 8'd1;
      pending_msgs.push_back(m);
    end else if (run_cmd >= CMD_NOTE_OFF && run_cmd <= CMD_CTRL_CHG) begin
      if (run_count == 2'd0) begin
        run_first = w[6:0];
        run_count = 2'd1;
      end else begin
        run_count = 2'd0;
        case (run_cmd)
          CMD_NOTE_OFF:   m.kind = KIND_NOTE_OFF;
          CMD_NOTE_ON:    m.kind = KIND_NOTE_ON;
          CMD_POLY_PRESS: m.kind = KIND_POLY_PRESS;
          default:        m.kind = KIND_CTRL_CHG;
        endcase
        m.chan   = {1'b0, run_chan} + 5'd1;
        m.first  = {1'b0, run_first};
        m.second = w[6:0];
        pending_msgs.push_back(m);
      end
    end else begin
      // With any other command the first word is kept and the words are counted, and the count stops at two.
      if (run_count == 2'd0) run_first = w[6:0];
      if (run_count < 2'd2) run_count++;
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= word_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_wanted != 0) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= hold_wanted) begin
        hold_wanted = 0;
        hold_count  = 0;
      end
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) begin
        words_taken++;
        decode_word(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        msgs_seen++;
        kinds_seen[out_msg_kind]++;
        if (pending_msgs.size() == 0) begin
          $error("unexpected message: kind %0d, channel %0d", out_msg_kind, out_chan_num);
          errors++;
        end else begin
          want = pending_msgs.pop_front();
          check_field("msg_kind", int'(want.kind), int'(out_msg_kind));
          check_field("chan_num", int'(want.chan), int'(out_chan_num));
          check_field("first_value", int'(want.first), int'(out_first_value));
          check_field("second_value", int'(want.second), int'(out_second_value));
          check_field("raw_status", int'(want.raw), int'(out_raw_status));
        end
      end
    end
  end

  task automatic queue_word(input logic [7:0] w);
    word_q.push_back(w);
    if (w != RT_CLOCK && w != RT_SENSE) words_queued++;
  endtask

  task automatic queue_data(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) queue_word(8'($urandom_range(RT_CLOCK, RT_RESET)));
      queue_word({1'b0, 7'($urandom_range(127))});
    end
  endtask

  task automatic queue_random_message();
    int         pick;
    logic [3:0] cmd;
    pick = $urandom_range(99);
    if (pick < 70) begin
      cmd = 4'($urandom_range(CMD_NOTE_OFF, CMD_PROGRAM));
      if ($urandom_range(3) != 0) queue_word({cmd, 4'($urandom_range(15))});
      repeat ($urandom_range(1, 3)) queue_data(cmd == CMD_PROGRAM ? 1 : 2);
    end else if (pick < 85) begin
      queue_word(8'($urandom_range(FIRST_UNKNOWN, RT_RESET)));
      queue_data($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 3)) queue_word(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_all_done();
    while (word_q.size() != 0 || in_valid || pending_msgs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 59;
    queue_word(8'h00);
    queue_word(8'h7F);
    queue_word({CMD_NOTE_OFF, 4'h0});
    queue_word(8'h00);
    queue_word(8'h7F);
    queue_word({CMD_NOTE_ON, 4'hF});
    queue_word(8'h7F);
    queue_word(8'h00);
    queue_word(8'h3C);
    queue_word(8'h40);
    queue_word({CMD_POLY_PRESS, 4'h5});
    queue_word(8'h10);
    queue_word(RT_CLOCK);
    queue_word(8'h20);
    queue_word({CMD_CTRL_CHG, 4'h0});
    queue_word(8'h07);
    queue_word(8'h64);
    queue_word({CMD_PROGRAM, 4'h0});
    queue_word(8'h00);
    queue_word(8'h7F);
    queue_word({CMD_CHAN_PRESS, 4'h2});
    queue_word(8'h11);
    queue_word(8'h22);
    queue_word(8'h33);
    queue_word({CMD_PITCH_BEND, 4'hF});
    queue_word({CMD_SYSTEM, 4'h7});
    queue_word(RT_SENSE);
    queue_word(RT_RESET);
    while (words_queued < 140) queue_random_message();
    wait_all_done();

    // The output is held back for a long stretch while a flood of program changes
    // keeps arriving, so the internal queue fills and the input is stalled.
    hold_wanted = LONG_HOLD;
    queue_word({CMD_PROGRAM, 4'($urandom_range(15))});
    repeat (40) queue_word({1'b0, 7'($urandom_range(127))});
    wait_all_done();

    send_idle_pct = 59;
    recv_idle_pct = 7;
    while (words_queued < 280) queue_random_message();
    wait_all_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_queued < 420) queue_random_message();
    wait_all_done();
    repeat (8) @(posedge clk);

    $display("Covered %0d words in and %0d messages out: note off %0d, note on %0d, poly %0d,",
             words_taken, msgs_seen, kinds_seen[KIND_NOTE_OFF], kinds_seen[KIND_NOTE_ON],
             kinds_seen[KIND_POLY_PRESS]);
    $display("control %0d, program %0d, unknown %0d; input held back on %0d cycles.",
             kinds_seen[KIND_CTRL_CHG], kinds_seen[KIND_PROGRAM], kinds_seen[KIND_UNKNOWN],
             in_stall_cycles);
    if (errors == 0 && pending_msgs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/mcmp_pkg.sv
rtl/core/mcmp_front.sv
rtl/core/mcmp_queue.sv
rtl/core/mcmp_back.sv
rtl/core/midi_channel_message_parser_top.sv
bench/midi_channel_message_parser_top_tb.sv
